// ===== rtl/mqsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mqsb_pkg: shared types and constants of the multi-queue shared buffer
// Slot count, queue count, pointer widths, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

  localparam int SLOTS      = 16;
  localparam int QUEUES     = 4;
  localparam int DATA_WIDTH = 32;

  localparam int QID_W  = 2;
  localparam int PTR_W  = $clog2(SLOTS + 1);
  localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

  typedef enum logic {
    FN_ENQ = 1'b0,
    FN_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic              en;
    logic [SIDX_W-1:0] addr;
    logic [PTR_W-1:0]  val;
  } link_wr_t;

  typedef struct packed {
    logic                  en;
    logic [SIDX_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] val;
  } data_wr_t;

endpackage

`default_nettype wire

// ===== rtl/mqsb_slot_store.sv =====
// ----------------------------------------------------------------------------
// mqsb_slot_store: slot link and slot data arrays
// Link array resets to the initial free chain; data array has no reset.
// One link read, one data read, one write to each array per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_slot_store
  import mqsb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [SIDX_W-1:0]     link_raddr_i,
  output      logic [PTR_W-1:0]      link_rdata_o,
  input  wire logic [SIDX_W-1:0]     data_raddr_i,
  output      logic [DATA_WIDTH-1:0] data_rdata_o,
  input  wire link_wr_t              link_wr_i,
  input  wire data_wr_t              data_wr_i
);

  logic [PTR_W-1:0]      link_q [SLOTS];
  logic [DATA_WIDTH-1:0] data_q [SLOTS];

  // slot i points to i+1; the last one points to NIL
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        link_q[i] <= PTR_W'(i + 1);
      end
    end else if (link_wr_i.en) begin
      link_q[link_wr_i.addr] <= link_wr_i.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_wr_i.en) begin
      data_q[data_wr_i.addr] <= data_wr_i.val;
    end
  end

  assign link_rdata_o = link_q[link_raddr_i];
  assign data_rdata_o = data_q[data_raddr_i];

endmodule

`default_nettype wire

// ===== rtl/multi_queue_shared_buffer.sv =====
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer: several FIFO queues in one shared slot store
// Each queue is a linked list of slots; unused slots form a free stack.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one operation per item: tuser carries func (enqueue
//   or dequeue) and queue_id, tdata carries the value to enqueue.
//   Master stream returns one item per operation: tuser is the status
//   (ok, store full, queue empty), tdata the dequeued value or zero.
//   A result goes through the input register, then the list update writes
//   it into the result register; a stalled master side can hold it between.
//   Throughput is one item per cycle while the master side takes results;
//   lists update with the result register, so the next item sees them at once.
//   A stalled master side holds the result register; the input register
//   then fills and s_axis_tready drops until the result is taken.
//   Reset empties every queue, chains all slots into the free list and
//   drops both valids. No clearing pass: the block is ready right after
//   reset. Out-of-range queue numbers leave the lists unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_shared_buffer
  import mqsb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [DATA_WIDTH-1:0] s_axis_tdata,  // [31:0] data_in
  input  wire logic [2:0]            s_axis_tuser,  // [0] func, [2:1] queue_id
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [DATA_WIDTH-1:0] m_axis_tdata,  // [31:0] data_out
  output      logic [1:0]            m_axis_tuser   // [1:0] status
);

  // input register
  logic                  in_vld_q;
  func_e                 in_func_q;
  logic [QID_W-1:0]      in_qid_q;
  logic [DATA_WIDTH-1:0] in_data_q;

  // result register
  logic                  out_vld_q;
  status_e               out_status_q, out_status_d;
  logic [DATA_WIDTH-1:0] out_data_q, out_data_d;

  // list pointers
  logic [PTR_W-1:0] head_q [QUEUES];
  logic [PTR_W-1:0] tail_q [QUEUES];
  logic [PTR_W-1:0] free_head_q, free_head_d;
  logic [PTR_W-1:0] head_d, tail_d;
  logic             head_we, tail_we;

  logic                  adv, s_hs;
  logic                  q_ok, free_nil, hd_nil;
  logic                  enq_ok, deq_ok;
  logic [QIDX_W-1:0]     qidx;
  logic [PTR_W-1:0]      hd, tl, link_raddr, link_rdata;
  logic [DATA_WIDTH-1:0] data_rdata;
  link_wr_t              link_wr;
  data_wr_t              data_wr;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      in_func_q <= func_e'(s_axis_tuser[0]);
      in_qid_q  <= s_axis_tuser[2:1];
      in_data_q <= s_axis_tdata;
    end
  end

  assign q_ok     = ({{(32-QID_W){1'b0}}, in_qid_q} < 32'(QUEUES));
  assign qidx     = QIDX_W'(in_qid_q);
  assign hd       = head_q[qidx];
  assign tl       = tail_q[qidx];
  assign free_nil = (free_head_q >= NIL);
  assign hd_nil   = (hd >= NIL);
  assign enq_ok   = adv && (in_func_q == FN_ENQ) && q_ok && !free_nil;
  assign deq_ok   = adv && (in_func_q == FN_DEQ) && q_ok && !hd_nil;

  assign link_raddr = (in_func_q == FN_DEQ) ? hd : free_head_q;

  mqsb_slot_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .link_raddr_i (link_raddr[SIDX_W-1:0]),
    .link_rdata_o (link_rdata),
    .data_raddr_i (hd[SIDX_W-1:0]),
    .data_rdata_o (data_rdata),
    .link_wr_i    (link_wr),
    .data_wr_i    (data_wr)
  );

  // A one-slot queue is detected by head == tail, so a new tail slot's
  // link never needs to be cleared.
  always_comb begin
    free_head_d  = free_head_q;
    head_d       = hd;
    tail_d       = tl;
    head_we      = 1'b0;
    tail_we      = 1'b0;
    link_wr      = '0;
    data_wr      = '0;
    out_data_d   = '0;
    out_status_d = (in_func_q == FN_ENQ) ? ST_FULL : ST_EMPTY;
    if (enq_ok) begin
      out_status_d = ST_OK;
      free_head_d  = link_rdata;
      tail_d       = free_head_q;
      tail_we      = 1'b1;
      data_wr.en   = 1'b1;
      data_wr.addr = free_head_q[SIDX_W-1:0];
      data_wr.val  = in_data_q;
      if (hd_nil) begin
        head_d  = free_head_q;
        head_we = 1'b1;
      end else begin
        link_wr.en   = 1'b1;
        link_wr.addr = tl[SIDX_W-1:0];
        link_wr.val  = free_head_q;
      end
    end else if (deq_ok) begin
      out_status_d = ST_OK;
      out_data_d   = data_rdata;
      head_d       = (hd == tl) ? NIL : link_rdata;
      head_we      = 1'b1;
      free_head_d  = hd;
      link_wr.en   = 1'b1;
      link_wr.addr = hd[SIDX_W-1:0];
      link_wr.val  = free_head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
    end else begin
      free_head_q <= free_head_d;
      if (head_we) begin
        head_q[qidx] <= head_d;
      end
      if (tail_we) begin
        tail_q[qidx] <= tail_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  a_free_ptr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NIL)
    else $error("free list head out of range");

  a_fail_data_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q != ST_OK) |-> (out_data_q == '0))
    else $error("failed operation returned nonzero data");

  a_full_reported : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_func_q == FN_ENQ && free_nil) |=> (out_status_q == ST_FULL))
    else $error("enqueue on empty free list not reported full");

  a_deq_frees_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_ok |=> (free_head_q == $past(hd)))
    else $error("dequeued slot not returned to free list");

endmodule

`default_nettype wire
